// File: sv/sst_pkg.sv
// Shared types and constants for the script source tokenizer.
package sst_pkg;

   typedef enum logic [4:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_DEC,
      MODE_HEX,
      MODE_DASH,
      MODE_DASH2,
      MODE_DASH2BR,
      MODE_LINECOM,
      MODE_BLOCKCOM,
      MODE_BLOCKCLOSE,
      MODE_PEQ,
      MODE_PLT,
      MODE_PGT,
      MODE_PTILDE,
      MODE_PDOT,
      MODE_PDOTDOT
   } mode_type;

   typedef logic [4:0] kind_type;

   localparam kind_type KIND_EOF        = 5'd0;
   localparam kind_type KIND_ERROR      = 5'd1;
   localparam kind_type KIND_NUMBER     = 5'd2;
   localparam kind_type KIND_STRING     = 5'd3;
   localparam kind_type KIND_IDENT      = 5'd4;
   localparam kind_type KIND_TEXT       = 5'd5;
   localparam kind_type KIND_PLUS       = 5'd6;
   localparam kind_type KIND_MINUS      = 5'd7;
   localparam kind_type KIND_STAR       = 5'd8;
   localparam kind_type KIND_SLASH      = 5'd9;
   localparam kind_type KIND_PERCENT    = 5'd10;
   localparam kind_type KIND_CARET      = 5'd11;
   localparam kind_type KIND_HASH       = 5'd12;
   localparam kind_type KIND_LPAREN     = 5'd13;
   localparam kind_type KIND_RPAREN     = 5'd14;
   localparam kind_type KIND_LBRACE     = 5'd15;
   localparam kind_type KIND_RBRACE     = 5'd16;
   localparam kind_type KIND_LBRACKET   = 5'd17;
   localparam kind_type KIND_RBRACKET   = 5'd18;
   localparam kind_type KIND_SEMI       = 5'd19;
   localparam kind_type KIND_COLON      = 5'd20;
   localparam kind_type KIND_COMMA      = 5'd21;
   localparam kind_type KIND_EQ         = 5'd22;
   localparam kind_type KIND_EQEQ       = 5'd23;
   localparam kind_type KIND_TILDEEQ    = 5'd24;
   localparam kind_type KIND_LT         = 5'd25;
   localparam kind_type KIND_LTEQ       = 5'd26;
   localparam kind_type KIND_GT         = 5'd27;
   localparam kind_type KIND_GTEQ       = 5'd28;
   localparam kind_type KIND_DOT        = 5'd29;
   localparam kind_type KIND_DOTDOT     = 5'd30;
   localparam kind_type KIND_DOTDOTDOT  = 5'd31;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
   localparam logic [1:0] ERR_LONE_TILDE = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   // Characters of a number that count, the 0x prefix included.
   localparam logic [3:0] NUMBER_CHARS = 4'd15;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] line;
      logic [15:0] num;
      logic [7:0]  ch;
      logic [1:0]  err;
      logic        last;
   } rec_type;

endpackage

// File: sv/script_source_tokenizer.sv
// Results are written into a registered result queue and offered on rsp from its head.
// Throughput: one source byte per cycle while the result side drains; a byte that causes
// two results pushes both into a 4-entry queue, which has a single result port.
// Input stalls while fewer than two queue entries are free.
// Reset (synchronous): scanner idle, line counters at one, error flag clear, queue empty.
module script_source_tokenizer
   import sst_pkg::*;
#(
   parameter int TEXT_LIMIT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] line_number, [31:16] number_value,
                                    // [39:32] text_char, [41:40] error_code, rest zero
   output logic [4:0]  rsp_tuser,   // [4:0] record_kind
   output logic        rsp_tlast    // last_result
);

   localparam int TL_W = (TEXT_LIMIT > 2) ? $clog2(TEXT_LIMIT) : 1;
   localparam logic [TL_W-1:0] TEXT_MAX = TL_W'(TEXT_LIMIT - 1);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;

   localparam int FIFO_DEPTH = 4;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == 8'h5F);
   endfunction

   // Bit 4 flags a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (is_digit(c))                      r = {1'b1, 4'(c - 8'h30)};
      else if ((c >= 8'h61) && (c <= 8'h66)) r = {1'b1, 4'(c - 8'h57)};
      else if ((c >= 8'h41) && (c <= 8'h46)) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   // Kind of a one-character operator, or KIND_EOF when the byte is none.
   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         8'h2B:   k = KIND_PLUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h25:   k = KIND_PERCENT;
         8'h5E:   k = KIND_CARET;
         8'h23:   k = KIND_HASH;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h5B:   k = KIND_LBRACKET;
         8'h5D:   k = KIND_RBRACKET;
         8'h3B:   k = KIND_SEMI;
         8'h3A:   k = KIND_COLON;
         8'h2C:   k = KIND_COMMA;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic rec_type mk_rec(input kind_type k, input logic [15:0] line,
                                      input logic [15:0] num, input logic [7:0] ch,
                                      input logic [1:0] err);
      rec_type r;
      r.kind = k;
      r.line = line;
      r.num  = num;
      r.ch   = ch;
      r.err  = err;
      r.last = 1'b0;
      return r;
   endfunction

   // Scanner state.
   mode_type        mode_ff, mode_in;
   logic [15:0]     line_ff, line_in;
   logic [15:0]     tsl_ff, tsl_in;
   logic [15:0]     acc_ff, acc_in;
   logic [3:0]      dcnt_ff, dcnt_in;
   logic [TL_W-1:0] tlen_ff, tlen_in;
   logic            dquote_ff, dquote_in;
   logic            err_ff, err_in;

   // Result queue.
   rec_type         fifo_ff [FIFO_DEPTH];
   logic [1:0]      rd_ptr_ff, wr_ptr_ff;
   logic [2:0]      fcnt_ff;

   logic [7:0]      c;
   logic            is_eof;
   logic            req_xfer, rsp_xfer;

   assign c        = req_tdata;
   assign is_eof   = req_tlast || (c == 8'h00);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Decode of a byte seen between tokens.
   logic            id_emit, id_nl, id_err, id_dquote;
   rec_type         id_rec;
   mode_type        id_mode;
   logic [TL_W-1:0] id_tlen;
   logic [15:0]     id_acc;
   logic [3:0]      id_dcnt;
   kind_type        id_op;

   always_comb begin
      id_op     = single_kind(c);
      id_emit   = 1'b0;
      id_rec    = mk_rec(KIND_EOF, line_ff, 16'd0, 8'd0, ERR_NONE);
      id_mode   = MODE_IDLE;
      id_nl     = 1'b0;
      id_err    = 1'b0;
      id_dquote = dquote_ff;
      id_tlen   = tlen_ff;
      id_acc    = acc_ff;
      id_dcnt   = dcnt_ff;
      priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
         id_mode = MODE_IDLE;
      end else if (c == CH_NL) begin
         id_nl = 1'b1;
      end else if (c == CH_MINUS) begin
         id_mode = MODE_DASH;
      end else if (c == CH_DQ || c == CH_SQ) begin
         id_dquote = (c == CH_DQ);
         id_tlen   = '0;
         id_mode   = MODE_STRING;
      end else if (is_digit(c)) begin
         id_acc  = 16'(c - CH_ZERO);
         id_dcnt = 4'd1;
         id_mode = MODE_DEC;
      end else if (is_alpha(c)) begin
         // The first identifier character fits under the text limit whenever TEXT_LIMIT is two or more.
         id_tlen = TL_W'(1);
         id_mode = MODE_IDENT;
         id_emit = 1'b1;
         id_rec  = mk_rec(KIND_TEXT, line_ff, 16'd0, c, ERR_NONE);
      end else if (id_op != KIND_EOF) begin
         id_emit = 1'b1;
         id_rec  = mk_rec(id_op, line_ff, 16'd0, 8'd0, ERR_NONE);
      end else if (c == CH_EQ) begin
         id_mode = MODE_PEQ;
      end else if (c == CH_LT) begin
         id_mode = MODE_PLT;
      end else if (c == CH_GT) begin
         id_mode = MODE_PGT;
      end else if (c == CH_TILDE) begin
         id_mode = MODE_PTILDE;
      end else if (c == CH_DOT) begin
         id_mode = MODE_PDOT;
      end else begin
         id_emit = 1'b1;
         id_err  = 1'b1;
         id_rec  = mk_rec(KIND_ERROR, line_ff, 16'd0, 8'd0, ERR_UNEXPECTED);
      end
   end

   // One byte step: an optional record for the token the byte closes, then an
   // optional record from the byte itself.
   logic            pre_v, main_v, call_idle;
   rec_type         pre_rec, main_rec;
   logic            keep_ok;
   logic [7:0]      esc_ch;
   logic [4:0]      hx;
   logic [15:0]     dec_next, hex_next;

   always_comb begin
      keep_ok  = tlen_ff < TEXT_MAX;
      hx       = hex_digit(c);
      dec_next = (acc_ff << 3) + (acc_ff << 1) + 16'(c - CH_ZERO);
      hex_next = (acc_ff << 4) + 16'(hx[3:0]);
      unique case (c)
         CH_N:    esc_ch = CH_NL;
         CH_R:    esc_ch = CH_CR;
         CH_T:    esc_ch = CH_TAB;
         default: esc_ch = c;
      endcase

      mode_in   = mode_ff;
      line_in   = line_ff;
      tsl_in    = tsl_ff;
      acc_in    = acc_ff;
      dcnt_in   = dcnt_ff;
      tlen_in   = tlen_ff;
      dquote_in = dquote_ff;
      err_in    = err_ff;
      pre_v     = 1'b0;
      main_v    = 1'b0;
      call_idle = 1'b0;
      pre_rec   = mk_rec(KIND_EOF, tsl_ff, 16'd0, 8'd0, ERR_NONE);
      main_rec  = mk_rec(KIND_EOF, tsl_ff, 16'd0, 8'd0, ERR_NONE);

      if (is_eof) begin
         if (!err_ff) begin
            pre_v = 1'b1;
            unique case (mode_ff)
               MODE_IDENT:   pre_rec.kind = KIND_IDENT;
               MODE_STRING, MODE_ESCAPE:
                  pre_rec = mk_rec(KIND_ERROR, line_ff, 16'd0, 8'd0, ERR_UNTERM_STR);
               MODE_DEC, MODE_HEX: begin
                  pre_rec.kind = KIND_NUMBER;
                  pre_rec.num  = acc_ff;
               end
               MODE_DASH:    pre_rec.kind = KIND_MINUS;
               MODE_PEQ:     pre_rec.kind = KIND_EQ;
               MODE_PLT:     pre_rec.kind = KIND_LT;
               MODE_PGT:     pre_rec.kind = KIND_GT;
               MODE_PTILDE:
                  pre_rec = mk_rec(KIND_ERROR, line_ff, 16'd0, 8'd0, ERR_LONE_TILDE);
               MODE_PDOT:    pre_rec.kind = KIND_DOT;
               MODE_PDOTDOT: pre_rec.kind = KIND_DOTDOT;
               default:      pre_v = 1'b0;
            endcase
         end
         main_v    = 1'b1;
         main_rec  = mk_rec(KIND_EOF, line_ff, 16'd0, 8'd0, ERR_NONE);
         mode_in   = MODE_IDLE;
         line_in   = 16'd1;
         tsl_in    = 16'd1;
         acc_in    = '0;
         dcnt_in   = '0;
         tlen_in   = '0;
         dquote_in = 1'b0;
         err_in    = 1'b0;
      end else if (!err_ff) begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (keep_ok) begin
                     main_v   = 1'b1;
                     main_rec = mk_rec(KIND_TEXT, tsl_ff, 16'd0, c, ERR_NONE);
                     tlen_in  = tlen_ff + TL_W'(1);
                  end
               end else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_IDENT;
                  call_idle    = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == (dquote_ff ? CH_DQ : CH_SQ)) begin
                  main_v        = 1'b1;
                  main_rec.kind = KIND_STRING;
                  mode_in       = MODE_IDLE;
               end else if (c == CH_BSL) begin
                  mode_in = MODE_ESCAPE;
               end else if (c == CH_NL) begin
                  main_v   = 1'b1;
                  main_rec = mk_rec(KIND_ERROR, line_ff, 16'd0, 8'd0, ERR_UNTERM_STR);
                  err_in   = 1'b1;
                  mode_in  = MODE_IDLE;
               end else if (keep_ok) begin
                  main_v   = 1'b1;
                  main_rec = mk_rec(KIND_TEXT, tsl_ff, 16'd0, c, ERR_NONE);
                  tlen_in  = tlen_ff + TL_W'(1);
               end
            end
            MODE_ESCAPE: begin
               if (c == CH_NL) line_in = line_ff + 16'd1;
               mode_in = MODE_STRING;
               if (keep_ok) begin
                  main_v   = 1'b1;
                  main_rec = mk_rec(KIND_TEXT, tsl_ff, 16'd0, esc_ch, ERR_NONE);
                  tlen_in  = tlen_ff + TL_W'(1);
               end
            end
            MODE_DEC: begin
               if (is_digit(c)) begin
                  if (dcnt_ff < NUMBER_CHARS) begin
                     acc_in  = dec_next;
                     dcnt_in = dcnt_ff + 4'd1;
                  end
               end else if ((c == CH_X_LO || c == CH_X_UP) && dcnt_ff == 4'd1 &&
                            acc_ff == 16'd0) begin
                  dcnt_in = 4'd2;
                  mode_in = MODE_HEX;
               end else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_NUMBER;
                  pre_rec.num  = acc_ff;
                  call_idle    = 1'b1;
               end
            end
            MODE_HEX: begin
               if (hx[4]) begin
                  if (dcnt_ff < NUMBER_CHARS) begin
                     acc_in  = hex_next;
                     dcnt_in = dcnt_ff + 4'd1;
                  end
               end else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_NUMBER;
                  pre_rec.num  = acc_ff;
                  call_idle    = 1'b1;
               end
            end
            MODE_DASH: begin
               if (c == CH_MINUS) mode_in = MODE_DASH2;
               else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_MINUS;
                  call_idle    = 1'b1;
               end
            end
            MODE_DASH2, MODE_DASH2BR: begin
               if (c == CH_LBRK) begin
                  mode_in = (mode_ff == MODE_DASH2) ? MODE_DASH2BR : MODE_BLOCKCOM;
               end else if (c == CH_NL) begin
                  line_in = line_ff + 16'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = MODE_LINECOM;
               end
            end
            MODE_LINECOM: begin
               if (c == CH_NL) begin
                  line_in = line_ff + 16'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_BLOCKCOM: begin
               if (c == CH_RBRK) mode_in = MODE_BLOCKCLOSE;
               else if (c == CH_NL) line_in = line_ff + 16'd1;
            end
            MODE_BLOCKCLOSE: begin
               if (c == CH_RBRK) mode_in = MODE_IDLE;
               else begin
                  if (c == CH_NL) line_in = line_ff + 16'd1;
                  mode_in = MODE_BLOCKCOM;
               end
            end
            MODE_PEQ, MODE_PLT, MODE_PGT: begin
               if (c == CH_EQ) begin
                  main_v  = 1'b1;
                  mode_in = MODE_IDLE;
                  unique case (mode_ff)
                     MODE_PEQ: main_rec.kind = KIND_EQEQ;
                     MODE_PLT: main_rec.kind = KIND_LTEQ;
                     default:  main_rec.kind = KIND_GTEQ;
                  endcase
               end else begin
                  pre_v     = 1'b1;
                  call_idle = 1'b1;
                  unique case (mode_ff)
                     MODE_PEQ: pre_rec.kind = KIND_EQ;
                     MODE_PLT: pre_rec.kind = KIND_LT;
                     default:  pre_rec.kind = KIND_GT;
                  endcase
               end
            end
            MODE_PTILDE: begin
               main_v  = 1'b1;
               mode_in = MODE_IDLE;
               if (c == CH_EQ) main_rec.kind = KIND_TILDEEQ;
               else begin
                  // The byte after a lone tilde is dropped.
                  main_rec = mk_rec(KIND_ERROR, line_ff, 16'd0, 8'd0, ERR_LONE_TILDE);
                  err_in   = 1'b1;
               end
            end
            MODE_PDOT: begin
               if (c == CH_DOT) mode_in = MODE_PDOTDOT;
               else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_DOT;
                  call_idle    = 1'b1;
               end
            end
            MODE_PDOTDOT: begin
               if (c == CH_DOT) begin
                  main_v        = 1'b1;
                  main_rec.kind = KIND_DOTDOTDOT;
                  mode_in       = MODE_IDLE;
               end else begin
                  pre_v        = 1'b1;
                  pre_rec.kind = KIND_DOTDOT;
                  call_idle    = 1'b1;
               end
            end
            default: call_idle = 1'b1;
         endcase

         if (call_idle) begin
            mode_in   = id_mode;
            tsl_in    = line_ff;
            line_in   = line_ff + {15'd0, id_nl};
            dquote_in = id_dquote;
            tlen_in   = id_tlen;
            acc_in    = id_acc;
            dcnt_in   = id_dcnt;
            err_in    = id_err;
            main_v    = id_emit;
            main_rec  = id_rec;
         end
      end

      if (main_v) main_rec.last = 1'b1;
      else        pre_rec.last  = 1'b1;
   end

   // Queue write side: the first pushed record goes to wr_ptr, a second one after it.
   logic [1:0] push_n;
   rec_type    first_rec;

   assign push_n     = req_xfer ? ({1'b0, pre_v} + {1'b0, main_v}) : 2'd0;
   assign first_rec  = pre_v ? pre_rec : main_rec;
   assign req_tready = fcnt_ff <= 3'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= 16'd1;
         tsl_ff    <= 16'd1;
         acc_ff    <= '0;
         dcnt_ff   <= '0;
         tlen_ff   <= '0;
         dquote_ff <= 1'b0;
         err_ff    <= 1'b0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fcnt_ff   <= '0;
      end else begin
         if (req_xfer) begin
            mode_ff   <= mode_in;
            line_ff   <= line_in;
            tsl_ff    <= tsl_in;
            acc_ff    <= acc_in;
            dcnt_ff   <= dcnt_in;
            tlen_ff   <= tlen_in;
            dquote_ff <= dquote_in;
            err_ff    <= err_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, rsp_xfer};
         fcnt_ff   <= fcnt_ff + {1'b0, push_n} - {2'b00, rsp_xfer};
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_ff[wr_ptr_ff] <= first_rec;
      if (push_n == 2'd2) fifo_ff[wr_ptr_ff + 2'd1] <= main_rec;
   end

   rec_type head;
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = fcnt_ff != 3'd0;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {6'd0, head.err, head.ch, head.num, head.line};

   // Queue occupancy never exceeds its depth.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= 3'(FIFO_DEPTH))
      else $error("result queue overflow");

   // End of input returns the scanner to its reset state.
   a_eof_resets: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_eof) |=> (mode_ff == MODE_IDLE && line_ff == 16'd1 && !err_ff))
      else $error("end of input did not reset the scanner");

   // A latched error always leaves the scanner idle.
   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (mode_ff == MODE_IDLE))
      else $error("error latched outside idle");

   // Kept text never exceeds the limit.
   a_text_bound: assert property (@(posedge clock) disable iff (reset)
      tlen_ff <= TEXT_MAX)
      else $error("text length beyond limit");

   // When two records are pushed, only the second ends the byte's results.
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (!first_rec.last && main_rec.last))
      else $error("last flag misplaced in a record pair");

endmodule
